FILE: src/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg: shared types and constants of the text console engine
// Screen geometry, cell layout, function codes and sequencer states.
// ----------------------------------------------------------------------------
package tccs_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W  = $clog2(COLUMNS);
  // index compare width: wide enough for the input field and the cell count
  localparam int CMP_W  = (ADDR_W + 1 > 11) ? ADDR_W + 1 : 11;

  localparam int CELL_W = 16;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [CMP_W-1:0]  cmp_t;
  typedef logic [CELL_W-1:0] cell_t;

  typedef logic [1:0]  func_t;
  typedef logic [7:0]  byte_t;
  typedef logic [10:0] index_t;
  typedef logic [4:0]  row_field_t;
  typedef logic [6:0]  col_field_t;

  localparam func_t FUNC_PUT   = 2'd0;
  localparam func_t FUNC_CLEAR = 2'd1;
  localparam func_t FUNC_READ  = 2'd2;

  localparam byte_t NEWLINE_CODE = 8'h0A;
  localparam byte_t SPACE_CODE   = 8'h20;
  // bottom row after a scroll: space with a zero attribute
  localparam cell_t SCROLL_BLANK = {8'h00, SPACE_CODE};

  localparam addr_t LAST_CELL   = addr_t'(CELL_COUNT - 1);
  localparam addr_t SCROLL_LAST = addr_t'(CELL_COUNT - COLUMNS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDWAIT,
    ST_SCROLL,
    ST_BLANK,
    ST_CLEAR,
    ST_DONE
  } state_e;

  typedef struct packed {
    func_t  func;
    byte_t  char_code;
    index_t cell_index;
  } item_t;

  typedef struct packed {
    row_field_t cursor_row;
    col_field_t cursor_col;
    cell_t      cell_entry;
  } result_t;

endpackage

FILE: src/text_console_cursor_scroll.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll: text console engine with cursor and scroll
// Cell store, cursor, color register and a stream interface per item.
// ----------------------------------------------------------------------------
// A put without a line break at the bottom row, an unused function code and a
// read of an index outside the store go from acceptance straight to the result
// state; a read inside the store passes a wait state first (registered store
// read). A line break on the bottom row scrolls the store through its single
// write port: every moved cell and then every blanked cell of the bottom row
// is written in turn. A clear writes every cell once. The input is not ready
// while an item is at work; a finished result waits in the output register
// and the next item is taken meanwhile. cell_entry is 0 except for reads.
module text_console_cursor_scroll (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,     // text_color
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // func[1:0], char_code[9:2], cell_index[20:10]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o   // cursor_row[4:0], cursor_col[11:5], cell_entry[27:12]
);

  tccs_pkg::byte_t   color_q;
  tccs_pkg::item_t   item;
  tccs_pkg::result_t result;
  tccs_pkg::result_t out_q;
  logic              out_valid_q;
  logic              accept;
  logic              idle;
  logic              done;
  logic              out_free;
  logic              ram_we;
  tccs_pkg::addr_t   ram_waddr;
  tccs_pkg::cell_t   ram_wdata;
  tccs_pkg::addr_t   ram_raddr;
  tccs_pkg::cell_t   ram_rdata;

  assign item.func       = s_axis_tdata_i[1:0];
  assign item.char_code  = s_axis_tdata_i[9:2];
  assign item.cell_index = s_axis_tdata_i[20:10];

  assign s_axis_tready_o = idle;
  assign accept          = s_axis_tvalid_i && idle;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= 8'h07;
    end else if (cfg_we_i) begin
      color_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, out_q.cell_entry, out_q.cursor_col, out_q.cursor_row};

  tccs_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (item),
    .color_i     (color_q),
    .out_free_i  (out_free),
    .idle_o      (idle),
    .done_o      (done),
    .result_o    (result),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  tccs_ram #(
    .WIDTH (tccs_pkg::CELL_W),
    .DEPTH (tccs_pkg::CELL_COUNT)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

FILE: src/tccs_ram.sv
// ----------------------------------------------------------------------------
// tccs_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/tccs_seq.sv
// ----------------------------------------------------------------------------
// tccs_seq: console sequencer
// Cursor state, one shared cell address counter and the control of the
// cell store for put, line break, scroll, clear and read.
// ----------------------------------------------------------------------------
module tccs_seq (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  tccs_pkg::item_t          item_i,
  input  tccs_pkg::byte_t          color_i,
  input  logic                     out_free_i,
  output logic                     idle_o,
  output logic                     done_o,
  output tccs_pkg::result_t        result_o,
  output logic                     ram_we_o,
  output tccs_pkg::addr_t          ram_waddr_o,
  output tccs_pkg::cell_t          ram_wdata_o,
  output tccs_pkg::addr_t          ram_raddr_o,
  input  tccs_pkg::cell_t          ram_rdata_i
);

  tccs_pkg::state_e state_q, state_d;
  tccs_pkg::addr_t  cnt_q, cnt_d;
  tccs_pkg::row_t   row_q, row_d;
  tccs_pkg::col_t   col_q, col_d;
  tccs_pkg::cell_t  entry_q, entry_d;

  logic            is_newline;
  logic            line_break;
  logic            at_bottom;
  logic            index_ok;
  tccs_pkg::addr_t cursor_addr;

  assign is_newline  = (item_i.char_code == tccs_pkg::NEWLINE_CODE);
  assign line_break  = is_newline || (col_q == tccs_pkg::col_t'(tccs_pkg::COLUMNS - 1));
  assign at_bottom   = (row_q == tccs_pkg::row_t'(tccs_pkg::ROWS - 1));
  assign index_ok    = (tccs_pkg::cmp_t'(item_i.cell_index)
                        < tccs_pkg::cmp_t'(tccs_pkg::CELL_COUNT));
  assign cursor_addr = tccs_pkg::addr_t'(row_q) * tccs_pkg::addr_t'(tccs_pkg::COLUMNS)
                       + tccs_pkg::addr_t'(col_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tccs_pkg::ST_IDLE: begin
        if (accept_i) begin
          case (item_i.func)
            tccs_pkg::FUNC_PUT: begin
              state_d = (line_break && at_bottom) ? tccs_pkg::ST_SCROLL : tccs_pkg::ST_DONE;
            end
            tccs_pkg::FUNC_CLEAR: state_d = tccs_pkg::ST_CLEAR;
            tccs_pkg::FUNC_READ: begin
              state_d = index_ok ? tccs_pkg::ST_RDWAIT : tccs_pkg::ST_DONE;
            end
            default: state_d = tccs_pkg::ST_DONE;
          endcase
        end
      end
      tccs_pkg::ST_RDWAIT: state_d = tccs_pkg::ST_DONE;
      tccs_pkg::ST_SCROLL: begin
        if (cnt_q == tccs_pkg::SCROLL_LAST) begin
          state_d = tccs_pkg::ST_BLANK;
        end
      end
      tccs_pkg::ST_BLANK, tccs_pkg::ST_CLEAR: begin
        if (cnt_q == tccs_pkg::LAST_CELL) begin
          state_d = tccs_pkg::ST_DONE;
        end
      end
      tccs_pkg::ST_DONE: begin
        if (out_free_i) begin
          state_d = tccs_pkg::ST_IDLE;
        end
      end
      default: state_d = tccs_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    cnt_d       = cnt_q;
    row_d       = row_q;
    col_d       = col_q;
    entry_d     = entry_q;
    done_o      = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = cnt_q;
    ram_wdata_o = {color_i, tccs_pkg::SPACE_CODE};
    ram_raddr_o = tccs_pkg::addr_t'(item_i.cell_index);
    case (state_q)
      tccs_pkg::ST_IDLE: begin
        if (accept_i) begin
          entry_d = '0;
          cnt_d   = '0;
          if (item_i.func == tccs_pkg::FUNC_PUT) begin
            if (!is_newline) begin
              ram_we_o    = 1'b1;
              ram_waddr_o = cursor_addr;
              ram_wdata_o = {color_i, item_i.char_code};
            end
            if (line_break) begin
              col_d = '0;
              if (!at_bottom) begin
                row_d = tccs_pkg::row_t'(row_q + 1'b1);
              end
            end else begin
              col_d = tccs_pkg::col_t'(col_q + 1'b1);
            end
          end
        end
      end
      tccs_pkg::ST_RDWAIT: entry_d = ram_rdata_i;
      tccs_pkg::ST_SCROLL: begin
        // read one row ahead, write the word read in the previous cycle
        ram_raddr_o = cnt_q + tccs_pkg::addr_t'(tccs_pkg::COLUMNS);
        ram_we_o    = (cnt_q != '0);
        ram_waddr_o = cnt_q - 1'b1;
        ram_wdata_o = ram_rdata_i;
        if (cnt_q != tccs_pkg::SCROLL_LAST) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      tccs_pkg::ST_BLANK: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = tccs_pkg::SCROLL_BLANK;
        cnt_d       = cnt_q + 1'b1;
      end
      tccs_pkg::ST_CLEAR: begin
        ram_we_o = 1'b1;
        cnt_d    = cnt_q + 1'b1;
      end
      tccs_pkg::ST_DONE: done_o = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tccs_pkg::ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign idle_o              = (state_q == tccs_pkg::ST_IDLE);
  assign result_o.cursor_row = tccs_pkg::row_field_t'(row_q);
  assign result_o.cursor_col = tccs_pkg::col_field_t'(col_q);
  assign result_o.cell_entry = entry_q;

endmodule
